// ===== hw/rtl/vt4_pkg.sv =====
`default_nettype none
package vt4_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int FP_W     = 32;

    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_DIR   = 2'd1;
    localparam logic [1:0] OP_FULL  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
    };

    typedef logic [NUM_REGS-1:0][REG_W-1:0] vt4_mat_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
        logic [31:0] in_w;
    } vt4_in_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
    } vt4_out_t;

    // Matrix element M[row][col] out of the register file.
    function automatic logic [31:0] mat_elem(input vt4_mat_t m, input int row, input int col);
        logic [63:0] r;
        r = m[row * 2 + col / 2];
        return (col % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Normalizes and rounds to nearest even. The MSB of sig carries weight
    // 2^(exp-127); subnormal and overflow results come out as IEEE requires.
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [10:0] exp,
                                              input logic [47:0] sig);
        logic [5:0]         lz;
        logic signed [10:0] e;
        logic signed [10:0] shf;
        logic [5:0]         sh;
        logic [47:0]        s;
        logic [47:0]        s_sh;
        logic               sticky;
        logic [23:0]        mant;
        logic               inc;
        logic [33:0]        pk;
        logic [10:0]        ex;
        lz     = lzc48(sig);
        e      = exp - $signed({5'b0, lz});
        s      = sig << lz;
        sticky = 1'b0;
        if (e < 11'sd1) begin
            shf    = 11'sd1 - e;
            sh     = (shf > 11'sd63) ? 6'd63 : shf[5:0];
            s_sh   = s >> sh;
            sticky = |(s & ~({48{1'b1}} << sh));
            s      = s_sh;
            e      = 11'sd1;
        end
        mant = s[47:24];
        inc  = s[23] & ((|s[22:0]) | sticky | mant[0]);
        ex   = e[10:0] - 11'd1;
        pk   = {ex, 23'b0} + {10'b0, mant} + {33'b0, inc};
        if (sig == '0) begin
            return {sgn, 31'b0};
        end
        if (pk[33:23] >= 11'd255) begin
            return {sgn, INF_MAG};
        end
        return {sgn, pk[30:0]};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vt4_apb_regs.sv =====
`default_nettype none
module vt4_apb_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vt4_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [vt4_pkg::REG_W-1:0]     pwdata,
    output logic      [vt4_pkg::REG_W-1:0]     prdata,
    output logic                               pready,
    output vt4_pkg::vt4_mat_t                  mat
);

    vt4_pkg::vt4_mat_t mat_reg;
    vt4_pkg::vt4_mat_t mat_next;
    logic [2:0]        idx;

    assign idx = paddr[vt4_pkg::ADDR_W-1:3];

    always_comb
    begin
        mat_next = mat_reg;
        if (psel && penable && pwrite)
        begin
            mat_next[idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt4_pkg::NUM_REGS; i++)
            begin
                mat_reg[i] <= vt4_pkg::REG_RESET[i];
            end
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign prdata = mat_reg[idx];
    assign pready = 1'b1;
    assign mat    = mat_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_delay.sv =====
`default_nettype none
module vt4_delay #(
    parameter int W = 32,
    parameter int D = 2
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[D-1];

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_fmul.sv =====
`default_nettype none
// Two-stage fp32 multiplier: mantissa product, then normalize and round.
module vt4_fmul (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);

    logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [23:0]        ma, mb;
    logic [7:0]         ea, eb;
    logic               sgn_reg, nan_reg, inf_reg, zero_reg;
    logic signed [10:0] exp_reg;
    logic [47:0]        prod_reg;
    logic [31:0]        y_reg;
    logic [31:0]        y_next;

    assign a_zero = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
    assign b_zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign ma     = {a[30:23] != 8'd0, a[22:0]};
    assign mb     = {b[30:23] != 8'd0, b[22:0]};
    assign ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    assign eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg  <= a[31] ^ b[31];
            nan_reg  <= a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
            inf_reg  <= a_inf || b_inf;
            zero_reg <= a_zero || b_zero;
            // Bit 47 of the product weighs 2^(ea+eb-126-127).
            exp_reg  <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
            prod_reg <= ma * mb;
        end
    end

    always_comb
    begin
        priority if (nan_reg)
            y_next = vt4_pkg::CANON_NAN;
        else if (inf_reg)
            y_next = {sgn_reg, vt4_pkg::INF_MAG};
        else if (zero_reg)
            y_next = {sgn_reg, 31'b0};
        else
            y_next = vt4_pkg::fp_round(sgn_reg, exp_reg, prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_fadd.sv =====
`default_nettype none
// Two-stage fp32 adder: align and add, then normalize and round.
module vt4_fadd (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);

    logic [31:0]        big, sml;
    logic               a_inf, b_inf, a_nan, b_nan;
    logic [7:0]         e_big, e_sml, d;
    logic [27:0]        a_al, b_full, b_al;
    logic [27:0]        sum;
    logic               sgn_reg, zsgn_reg, nan_reg, inf_reg, isgn_reg;
    logic signed [10:0] exp_reg;
    logic [27:0]        sum_reg;
    logic [31:0]        y_reg;
    logic [31:0]        y_next;

    assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);

    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d      = e_big - e_sml;
        a_al   = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b0};
        b_full = {1'b0, sml[30:23] != 8'd0, sml[22:0], 3'b0};
        // Bits shifted past the guard positions fold into a sticky bit.
        if (d >= 8'd28)
            b_al = {27'b0, |b_full};
        else
            b_al = (b_full >> d[4:0]) | {27'b0, |(b_full & ~({28{1'b1}} << d[4:0]))};
        if (a[31] ^ b[31])
            sum = a_al - b_al;
        else
            sum = a_al + b_al;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg  <= big[31];
            zsgn_reg <= a[31] & b[31];
            nan_reg  <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
            inf_reg  <= a_inf || b_inf;
            isgn_reg <= a_inf ? a[31] : b[31];
            exp_reg  <= $signed({3'b0, e_big}) + 11'sd1;
            sum_reg  <= sum;
        end
    end

    always_comb
    begin
        priority if (nan_reg)
            y_next = vt4_pkg::CANON_NAN;
        else if (inf_reg)
            y_next = {isgn_reg, vt4_pkg::INF_MAG};
        else if (sum_reg == '0)
            y_next = {zsgn_reg, 31'b0};
        else
            y_next = vt4_pkg::fp_round(sgn_reg, exp_reg, {sum_reg, 20'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vertex_transform_4x4.sv =====
// Throughput: one word per cycle; every stage advances together whenever the
// output register is empty or being taken, so a stall holds the whole pipe.
// Per row: 2-stage multipliers, then three chained 2-stage adders, then the output register.
// Reset (rst_n low, asynchronous) empties the pipe and loads the identity matrix.
`default_nettype none
module vertex_transform_4x4 (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire vt4_pkg::vt4_in_t             in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output vt4_pkg::vt4_out_t                 out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vt4_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vt4_pkg::REG_W-1:0]    pwdata,
    output logic      [vt4_pkg::REG_W-1:0]    prdata,
    output logic                              pready
);

    localparam int DEPTH = 8;

    vt4_pkg::vt4_mat_t mat;
    logic              en;
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    logic [1:0]        op_reg [DEPTH];
    logic              out_valid_reg;
    logic              out_valid_next;
    vt4_pkg::vt4_out_t out_reg;
    vt4_pkg::vt4_out_t out_next;
    logic [31:0]       vin   [4];
    logic [31:0]       prod  [4][4];
    logic [31:0]       p2_d  [4];
    logic [31:0]       p3_d  [4];
    logic [31:0]       s1    [4];
    logic [31:0]       s2    [4];
    logic [31:0]       s2_d  [4];
    logic [31:0]       t3    [4];
    logic [31:0]       s3    [4];

    vt4_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign vin[0] = in_data.in_x;
    assign vin[1] = in_data.in_y;
    assign vin[2] = in_data.in_z;
    assign vin[3] = in_data.in_w;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            vt4_fmul u_mul (
                .clk (clk),
                .en  (en),
                .a   (vin[c]),
                .b   (vt4_pkg::mat_elem(mat, r, c)),
                .y   (prod[r][c])
            );
        end

        vt4_delay #(.W(32), .D(2)) u_p2_dly (
            .clk (clk), .en (en), .d (prod[r][2]), .q (p2_d[r])
        );
        vt4_delay #(.W(32), .D(4)) u_p3_dly (
            .clk (clk), .en (en), .d (prod[r][3]), .q (p3_d[r])
        );

        vt4_fadd u_add1 (
            .clk (clk), .en (en), .a (prod[r][0]), .b (prod[r][1]), .y (s1[r])
        );
        vt4_fadd u_add2 (
            .clk (clk), .en (en), .a (s1[r]), .b (p2_d[r]), .y (s2[r])
        );

        // A point adds the translation column itself, unmultiplied.
        assign t3[r] = (op_reg[5] == vt4_pkg::OP_POINT) ?
                       vt4_pkg::mat_elem(mat, r, 3) : p3_d[r];

        vt4_fadd u_add3 (
            .clk (clk), .en (en), .a (s2[r]), .b (t3[r]), .y (s3[r])
        );
        vt4_delay #(.W(32), .D(2)) u_s2_dly (
            .clk (clk), .en (en), .d (s2[r]), .q (s2_d[r])
        );
    end

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_valid};
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (en)
        begin
            out_valid_next = vld_reg[DEPTH-1];
            unique case (op_reg[DEPTH-1])
                vt4_pkg::OP_POINT:
                    out_next = '{out_x: s3[0], out_y: s3[1], out_z: s3[2], out_w: 32'd0};
                vt4_pkg::OP_DIR:
                    out_next = '{out_x: s2_d[0], out_y: s2_d[1], out_z: s2_d[2],
                                 out_w: 32'd0};
                vt4_pkg::OP_FULL:
                    out_next = '{out_x: s3[0], out_y: s3[1], out_z: s3[2], out_w: s3[3]};
                default:
                    out_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= vld_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= in_data.operation;
            for (int i = 1; i < DEPTH; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
